// ===== rtl/core/ready_queue_policy_scheduler_unit_assert.svh =====
// assertion macros for the scheduler
`ifndef READY_QUEUE_POLICY_SCHEDULER_UNIT_ASSERT_SVH
`define READY_QUEUE_POLICY_SCHEDULER_UNIT_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define RQS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("rqs assertion failed");
// next-cycle implication
`define RQS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("rqs assertion failed");
`endif

// ===== rtl/core/rqs_pkg.sv =====
// ---------------------------------------------------------------------------
// rqs_pkg
// shared types and constants of the ready-queue scheduler
// ---------------------------------------------------------------------------
package rqs_pkg;
	localparam int TableDepthDef = 16;

	typedef enum logic [1:0] {
		POL_FCFS = 2'd0,
		POL_SJF  = 2'd1,
		POL_PRIO = 2'd2,
		POL_HRRN = 2'd3
	} policy_t;

	localparam logic [1:0] MODE_PUSH = 2'd0;
	localparam logic [1:0] MODE_POP  = 2'd1;
	localparam logic [1:0] MODE_ADV  = 2'd2;
	// unused mode, behaves as an advance by zero ticks
	localparam logic [1:0] MODE_HOLD = 2'd3;

	localparam logic [2:0] ST_PUSHED = 3'd0;
	localparam logic [2:0] ST_POPPED = 3'd1;
	localparam logic [2:0] ST_EMPTY  = 3'd2;
	localparam logic [2:0] ST_FULL   = 3'd3;
	localparam logic [2:0] ST_ZERO   = 3'd4;
	localparam logic [2:0] ST_ADV    = 3'd5;

	typedef struct packed {
		logic [1:0]         mode;
		logic [15:0]        proc_id;
		logic [9:0]         remaining_time;
		logic [3:0]         prio;
		logic signed [31:0] last_run;
		logic [9:0]         advance;
	} req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [15:0]        out_id;
		logic [9:0]         out_remaining;
		logic [3:0]         out_prio;
		logic signed [31:0] out_last_run;
		logic [4:0]         occupancy;
	} rsp_t;

	typedef struct packed {
		logic [15:0] id;
		logic [9:0]  remaining;
		logic [3:0]  prio;
		logic [31:0] last_run;
		logic [31:0] arrival;
	} entry_t;
endpackage

// ===== rtl/core/rqs_req_if.sv =====
// ---------------------------------------------------------------------------
// rqs_req_if
// request channel of the scheduler
// ---------------------------------------------------------------------------
interface rqs_req_if;
	logic            valid;
	logic            ready;
	rqs_pkg::req_t   data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/rqs_rsp_if.sv =====
// ---------------------------------------------------------------------------
// rqs_rsp_if
// result channel of the scheduler
// ---------------------------------------------------------------------------
interface rqs_rsp_if;
	logic            valid;
	logic            ready;
	rqs_pkg::rsp_t   data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/ready_queue_policy_scheduler_unit.sv =====
// ---------------------------------------------------------------------------
// ready_queue_policy_scheduler_unit
// ready-queue table with a selectable pop policy
// ---------------------------------------------------------------------------
// usage: requests arrive on req (push, pop or advance time), one result per
// transaction leaves on rsp. the user writes the policy register through
// cfg_we/cfg_wdata only while the block is idle; the block does not check it.
// entries live in a synchronous memory, valid bits in flip-flops.
// steps of each transaction:
// push: lowest free slot from the valid bits, one memory write.
// advance: the idle state moves the current time and sets the result.
// pop: one entry is read per cycle, a valid one restarts the read pipeline
// after its compare, hrrn uses a two-stage cross multiply, then the winner
// is read again for the result.
// one transaction is in work at a time; req.ready is high only when idle.
// a finished result waits in the output register; while rsp is stalled the
// block holds the result and takes no new request.
// reset clears valid bits, arrival counter, current time and policy; the
// memory is not cleared since every read is gated by its valid bit.
// ---------------------------------------------------------------------------
module ready_queue_policy_scheduler_unit #(
	parameter int TABLE_DEPTH = rqs_pkg::TableDepthDef
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata,
	rqs_req_if.sink    req,
	rqs_rsp_if.source  rsp
);
	`include "ready_queue_policy_scheduler_unit_assert.svh"

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [2:0] {S_IDLE, S_PUSH, S_SCAN, S_CMP, S_READ, S_OUT} state_t;

	state_t                  state_q;
	rqs_pkg::req_t           req_q;
	rqs_pkg::rsp_t           rsp_q;
	logic                    rsp_valid_q;
	logic [TABLE_DEPTH-1:0]  valid_q;
	logic [31:0]             arr_q;
	logic [30:0]             now_q;
	rqs_pkg::policy_t        policy_q;
	logic [CW-1:0]           cnt_q;
	logic [CW-1:0]           scan_q;
	logic [AW-1:0]           rd_s1;
	logic                    rdv_s1;
	logic                    have_q;
	logic [AW-1:0]           best_q;
	rqs_pkg::entry_t         best_e_q;
	rqs_pkg::entry_t         cand_q;
	logic [AW-1:0]           cand_idx_q;
	logic signed [44:0]      lhs_q;
	logic signed [44:0]      rhs_q;
	logic                    free_found;
	logic [AW-1:0]           free_idx;

	rqs_pkg::entry_t mem [TABLE_DEPTH];
	rqs_pkg::entry_t rd_data;
	logic            mem_we;
	logic [AW-1:0]   mem_wa;
	logic [AW-1:0]   mem_ra;
	rqs_pkg::entry_t mem_wd;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_data <= mem[mem_ra];
	end

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = AW'(i);
			end
		end
	end

	// hrrn numerator: now - last - 1 + rem, 34 bits signed
	function automatic logic signed [33:0] hnum(input logic [30:0] now,
		input rqs_pkg::entry_t e);
		hnum = $signed({3'b000, now}) - $signed({{2{e.last_run[31]}}, e.last_run})
			- 34'sd1 + $signed({24'd0, e.remaining});
	endfunction

	logic signed [33:0] num_c;
	logic signed [33:0] num_b;
	logic [31:0]        age_c;
	logic [31:0]        age_b;
	logic               older;
	logic               pref;

	always_comb begin
		num_c = hnum(now_q, cand_q);
		num_b = hnum(now_q, best_e_q);
		age_c = arr_q - cand_q.arrival;
		age_b = arr_q - best_e_q.arrival;
		older = age_c > age_b;
		case (policy_q)
			rqs_pkg::POL_SJF:
				pref = (cand_q.remaining != best_e_q.remaining) ?
					(cand_q.remaining < best_e_q.remaining) : older;
			rqs_pkg::POL_PRIO:
				pref = (cand_q.prio != best_e_q.prio) ? (cand_q.prio < best_e_q.prio) : older;
			rqs_pkg::POL_HRRN:
				pref = (lhs_q != rhs_q) ? (lhs_q > rhs_q) : older;
			default:
				pref = older;
		endcase
	end

	assign mem_ra = (state_q == S_SCAN) ? scan_q[AW-1:0] : best_q;
	always_comb begin
		mem_we = (state_q == S_PUSH);
		mem_wa = req_q.remaining_time == '0 ? '0 : free_idx;
		mem_wd.id        = req_q.proc_id;
		mem_wd.remaining = req_q.remaining_time;
		mem_wd.prio      = req_q.prio;
		mem_wd.last_run  = req_q.last_run;
		mem_wd.arrival   = arr_q;
		if (req_q.remaining_time == '0 || !free_found) begin
			mem_we = 1'b0;
		end
	end

	assign req.ready = (state_q == S_IDLE) && !rsp_valid_q;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			valid_q     <= '0;
			arr_q       <= '0;
			now_q       <= '0;
			policy_q    <= rqs_pkg::POL_FCFS;
			cnt_q       <= '0;
			scan_q      <= '0;
			rdv_s1      <= 1'b0;
			have_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				policy_q <= rqs_pkg::policy_t'(cfg_wdata);
			end
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid && req.ready) begin
						req_q  <= req.data;
						scan_q <= '0;
						rdv_s1 <= 1'b0;
						have_q <= 1'b0;
						case (req.data.mode)
							rqs_pkg::MODE_PUSH: state_q <= S_PUSH;
							rqs_pkg::MODE_POP: state_q <= S_SCAN;
							default: begin
								logic [31:0] t;
								t = {1'b0, now_q} + ((req.data.mode == rqs_pkg::MODE_ADV) ?
									{22'd0, req.data.advance} : 32'd0);
								now_q <= t[31] ? 31'h7FFF_FFFF : t[30:0];
								rsp_q <= '{status: rqs_pkg::ST_ADV, occupancy: 5'(cnt_q),
									default: '0};
								rsp_valid_q <= 1'b1;
							end
						endcase
					end
				end
				S_PUSH: begin
					rsp_q <= '{status: rqs_pkg::ST_PUSHED, occupancy: 5'(cnt_q + 1'b1),
						default: '0};
					if (req_q.remaining_time == '0) begin
						rsp_q.status    <= rqs_pkg::ST_ZERO;
						rsp_q.occupancy <= 5'(cnt_q);
					end else if (!free_found) begin
						rsp_q.status    <= rqs_pkg::ST_FULL;
						rsp_q.occupancy <= 5'(cnt_q);
					end else begin
						valid_q[free_idx] <= 1'b1;
						arr_q <= arr_q + 32'd1;
						cnt_q <= cnt_q + 1'b1;
					end
					rsp_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_SCAN: begin
					// stage 1: memory read issued; stage 2: candidate latched
					rd_s1  <= scan_q[AW-1:0];
					rdv_s1 <= (scan_q < CW'(TABLE_DEPTH)) && valid_q[scan_q[AW-1:0]];
					if (scan_q < CW'(TABLE_DEPTH)) begin
						scan_q <= scan_q + 1'b1;
					end
					cand_q     <= rd_data;
					cand_idx_q <= rd_s1;
					if (rdv_s1) begin
						state_q <= S_CMP;
						rdv_s1  <= 1'b0;
						scan_q  <= scan_q;
					end else if (scan_q == CW'(TABLE_DEPTH)) begin
						state_q <= S_READ;
					end
				end
				S_CMP: begin
					// products registered, compare next cycle
					lhs_q  <= 45'(num_c * $signed({1'b0, best_e_q.remaining}));
					rhs_q  <= 45'(num_b * $signed({1'b0, cand_q.remaining}));
					have_q <= ~have_q ? 1'b1 : have_q;
					if (!have_q) begin
						best_q   <= cand_idx_q;
						best_e_q <= cand_q;
						state_q  <= S_SCAN;
					end else if (policy_q != rqs_pkg::POL_HRRN || rdv_s1) begin
						if (pref) begin
							best_q   <= cand_idx_q;
							best_e_q <= cand_q;
						end
						rdv_s1  <= 1'b0;
						state_q <= S_SCAN;
					end else begin
						rdv_s1 <= 1'b1;
					end
				end
				S_READ: begin
					state_q <= S_OUT;
				end
				default: begin
					if (!have_q) begin
						rsp_q <= '{status: rqs_pkg::ST_EMPTY, occupancy: 5'(cnt_q),
							default: '0};
					end else begin
						rsp_q.status        <= rqs_pkg::ST_POPPED;
						rsp_q.out_id        <= rd_data.id;
						rsp_q.out_remaining <= rd_data.remaining;
						rsp_q.out_prio      <= rd_data.prio;
						rsp_q.out_last_run  <= rd_data.last_run;
						rsp_q.occupancy     <= 5'(cnt_q - 1'b1);
						valid_q[best_q]     <= 1'b0;
						cnt_q               <= cnt_q - 1'b1;
					end
					rsp_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
			endcase
		end
	end

	`RQS_ASSERT_IMP(a_ready_idle, clk, arst_n, req.ready, state_q == S_IDLE)
	`RQS_ASSERT_IMP(a_cnt_match, clk, arst_n, 1'b1, $countones(valid_q) == cnt_q)
	`RQS_ASSERT_NXT(a_hold_rsp, clk, arst_n, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp_q))
	`RQS_ASSERT_IMP(a_pop_valid, clk, arst_n, state_q == S_OUT && have_q, valid_q[best_q])
endmodule

// ===== verif/tb_ready_queue_policy_scheduler_unit.sv =====
// ---------------------------------------------------------------------------
// tb_ready_queue_policy_scheduler_unit
// self-checking testbench of the ready-queue policy scheduler
// ---------------------------------------------------------------------------
// a directed part covers field extremes, empty pop, zero-time and full-table
// pushes, the unused mode and every policy. random phases under each policy
// follow. an in-bench model of the table predicts every result, and a
// checker compares each response transaction with the oldest prediction.
// in the random phases both channels stall at random, and the pattern changes within each phase.
// ---------------------------------------------------------------------------
module tb_ready_queue_policy_scheduler_unit;
	localparam int DEPTH      = 16;
	localparam int STALL_MAX  = 5000;
	localparam logic [30:0] CLOCK_MAX = 31'h7FFF_FFFF;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_wdata;

	rqs_req_if req_if ();
	rqs_rsp_if rsp_if ();

	ready_queue_policy_scheduler_unit #(.TABLE_DEPTH(DEPTH)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req_if.sink),
		.rsp      (rsp_if.source)
	);

	// table model
	logic        tbl_valid [DEPTH];
	logic [15:0] tbl_id [DEPTH];
	logic [9:0]  tbl_rem [DEPTH];
	logic [3:0]  tbl_prio [DEPTH];
	logic [31:0] tbl_last [DEPTH];
	logic [31:0] tbl_arrival [DEPTH];
	logic [31:0] arrival_cnt;
	logic [30:0] sim_clock;
	rqs_pkg::policy_t cur_policy;

	rqs_pkg::rsp_t pending_rsp [$];
	int   mismatches;
	int   sent_items;
	int   checked_rsp;
	int   tx_idle_pct;
	int   rx_idle_pct;
	int   quiet_cycles;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint ratio_num(int i);
		return longint'(sim_clock) - longint'($signed(tbl_last[i])) - 1
			+ longint'(tbl_rem[i]);
	endfunction

	function automatic bit wins_over(int a, int b);
		longint lhs;
		longint rhs;
		bit     older;
		older = (arrival_cnt - tbl_arrival[a]) > (arrival_cnt - tbl_arrival[b]);
		case (cur_policy)
			rqs_pkg::POL_SJF: begin
				if (tbl_rem[a] != tbl_rem[b])
					return tbl_rem[a] < tbl_rem[b];
				return older;
			end
			rqs_pkg::POL_PRIO: begin
				if (tbl_prio[a] != tbl_prio[b])
					return tbl_prio[a] < tbl_prio[b];
				return older;
			end
			rqs_pkg::POL_HRRN: begin
				lhs = ratio_num(a) * longint'(tbl_rem[b]);
				rhs = ratio_num(b) * longint'(tbl_rem[a]);
				if (lhs != rhs)
					return lhs > rhs;
				return older;
			end
			default: return older;
		endcase
	endfunction

	function automatic rqs_pkg::rsp_t schedule_step(rqs_pkg::req_t r);
		rqs_pkg::rsp_t o;
		int          slot;
		int          best;
		int          cnt;
		logic [31:0] t;
		o = '0;
		o.status = rqs_pkg::ST_ADV;
		if (r.mode == rqs_pkg::MODE_PUSH) begin
			slot = -1;
			for (int i = DEPTH - 1; i >= 0; i--)
				if (!tbl_valid[i]) slot = i;
			if (r.remaining_time == 0) begin
				o.status = rqs_pkg::ST_ZERO;
			end else if (slot < 0) begin
				o.status = rqs_pkg::ST_FULL;
			end else begin
				tbl_valid[slot]   = 1'b1;
				tbl_id[slot]      = r.proc_id;
				tbl_rem[slot]     = r.remaining_time;
				tbl_prio[slot]    = r.prio;
				tbl_last[slot]    = r.last_run;
				tbl_arrival[slot] = arrival_cnt;
				arrival_cnt       = arrival_cnt + 1;
				o.status          = rqs_pkg::ST_PUSHED;
			end
		end else if (r.mode == rqs_pkg::MODE_POP) begin
			best = -1;
			for (int i = 0; i < DEPTH; i++)
				if (tbl_valid[i] && (best < 0 || wins_over(i, best))) best = i;
			if (best < 0) begin
				o.status = rqs_pkg::ST_EMPTY;
			end else begin
				o.out_id        = tbl_id[best];
				o.out_remaining = tbl_rem[best];
				o.out_prio      = tbl_prio[best];
				o.out_last_run  = tbl_last[best];
				tbl_valid[best] = 1'b0;
				o.status        = rqs_pkg::ST_POPPED;
			end
		end else begin
			t = {1'b0, sim_clock} +
				((r.mode == rqs_pkg::MODE_ADV) ? {22'd0, r.advance} : 32'd0);
			sim_clock = (t > {1'b0, CLOCK_MAX}) ? CLOCK_MAX : t[30:0];
		end
		cnt = 0;
		for (int i = 0; i < DEPTH; i++) cnt += tbl_valid[i];
		o.occupancy = cnt[4:0];
		return o;
	endfunction

	task automatic send_item(rqs_pkg::req_t r);
		if ($urandom_range(99) < tx_idle_pct) begin
			@(negedge clk);
			req_if.valid <= 1'b0;
			repeat ($urandom_range(4)) @(negedge clk);
		end
		@(negedge clk);
		req_if.valid <= 1'b1;
		req_if.data  <= r;
		do @(posedge clk); while (!req_if.ready);
		pending_rsp.push_back(schedule_step(r));
		sent_items++;
		@(negedge clk);
		req_if.valid <= 1'b0;
	endtask

	task automatic drain;
		while (pending_rsp.size() != 0) @(posedge clk);
		@(negedge clk);
		req_if.valid <= 1'b0;
		repeat (24) @(negedge clk);
	endtask

	task automatic set_policy(rqs_pkg::policy_t p);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= p;
		cur_policy = p;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic rqs_pkg::req_t mk_push(logic [15:0] id, logic [9:0] rem,
		logic [3:0] pr, logic [31:0] last);
		rqs_pkg::req_t r;
		r = '0;
		r.mode = rqs_pkg::MODE_PUSH;
		r.proc_id = id;
		r.remaining_time = rem;
		r.prio = pr;
		r.last_run = last;
		return r;
	endfunction

	function automatic rqs_pkg::req_t mk_ctrl(logic [1:0] m, logic [9:0] adv);
		rqs_pkg::req_t r;
		r = '0;
		r.proc_id = 16'($urandom());
		r.remaining_time = 10'($urandom());
		r.prio = 4'($urandom());
		r.last_run = $urandom();
		r.mode = m;
		r.advance = adv;
		return r;
	endfunction

	function automatic rqs_pkg::req_t random_req();
		rqs_pkg::req_t r;
		int   pick;
		r = '0;
		r.proc_id = 16'($urandom());
		r.remaining_time = 10'($urandom());
		r.prio = 4'($urandom());
		r.last_run = $urandom();
		r.advance = 10'($urandom());
		pick = $urandom_range(99);
		if (pick < 50) begin
			r.mode = rqs_pkg::MODE_PUSH;
			if ($urandom_range(19) == 0) r.remaining_time = '0;
			else if ($urandom_range(1)) r.remaining_time = 10'($urandom_range(1, 40));
			case ($urandom_range(5))
				0: r.last_run = 32'hFFFF_FFFF;
				1: r.last_run = $urandom();
				default: r.last_run = $urandom_range(sim_clock + 200);
			endcase
		end else if (pick < 85) begin
			r.mode = rqs_pkg::MODE_POP;
		end else if (pick < 97) begin
			r.mode = rqs_pkg::MODE_ADV;
		end else begin
			r.mode = rqs_pkg::MODE_HOLD;
		end
		return r;
	endfunction

	task automatic test_directed;
		set_policy(rqs_pkg::POL_FCFS);
		send_item(mk_ctrl(rqs_pkg::MODE_POP, 10'd0));
		send_item(mk_push(16'h1234, 10'd0, 4'd3, 32'd5));
		send_item(mk_push(16'h0000, 10'd1, 4'd0, 32'hFFFF_FFFF));
		send_item(mk_push(16'hFFFF, 10'd1023, 4'd15, 32'h7FFF_FFFF));
		for (int i = 0; i < 14; i++)
			send_item(mk_push(16'(i + 100), 10'(i % 3 + 1), 4'(i % 4), 32'(i)));
		send_item(mk_push(16'hBEEF, 10'd7, 4'd1, 32'd0));
		send_item(mk_ctrl(rqs_pkg::MODE_ADV, 10'd1023));
		send_item(mk_ctrl(rqs_pkg::MODE_HOLD, 10'd1023));
		set_policy(rqs_pkg::POL_HRRN);
		send_item(mk_ctrl(rqs_pkg::MODE_POP, 10'd0));
		set_policy(rqs_pkg::POL_PRIO);
		send_item(mk_ctrl(rqs_pkg::MODE_POP, 10'd0));
		set_policy(rqs_pkg::POL_SJF);
		send_item(mk_ctrl(rqs_pkg::MODE_POP, 10'd0));
	endtask

	task automatic test_random(rqs_pkg::policy_t p, int n);
		set_policy(p);
		for (int i = 0; i < n; i++) begin
			if (i < n / 3) begin
				tx_idle_pct = 19;
				rx_idle_pct = 77;
			end else if (i < 2 * n / 3) begin
				tx_idle_pct = 77;
				rx_idle_pct = 19;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			send_item(random_req());
		end
	endtask

	always @(negedge clk) begin
		rsp_if.ready <= arst_n && ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		rqs_pkg::rsp_t exp_rsp;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			checked_rsp++;
			if (pending_rsp.size() == 0) begin
				mismatches++;
				$display("%0t unexpected transaction: actual %p", $time, rsp_if.data);
			end else begin
				exp_rsp = pending_rsp.pop_front();
				if (rsp_if.data.status !== exp_rsp.status ||
					rsp_if.data.out_id !== exp_rsp.out_id ||
					rsp_if.data.out_remaining !== exp_rsp.out_remaining ||
					rsp_if.data.out_prio !== exp_rsp.out_prio ||
					rsp_if.data.out_last_run !== exp_rsp.out_last_run ||
					rsp_if.data.occupancy !== exp_rsp.occupancy) begin
					mismatches++;
					$display("%0t mismatch: expected %p actual %p", $time, exp_rsp,
						rsp_if.data);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_MAX) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		req_if.valid  = 1'b0;
		req_if.data   = '0;
		mismatches    = 0;
		sent_items    = 0;
		checked_rsp   = 0;
		tx_idle_pct   = 0;
		rx_idle_pct   = 0;
		arrival_cnt   = '0;
		sim_clock     = '0;
		cur_policy    = rqs_pkg::POL_FCFS;
		for (int i = 0; i < DEPTH; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_id[i] = '0;
			tbl_rem[i] = '0;
			tbl_prio[i] = '0;
			tbl_last[i] = '0;
			tbl_arrival[i] = '0;
		end
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random(rqs_pkg::POL_FCFS, 310);
		test_random(rqs_pkg::POL_SJF, 310);
		test_random(rqs_pkg::POL_PRIO, 310);
		test_random(rqs_pkg::POL_HRRN, 310);
		drain();
		$display("sent %0d transactions, checked %0d results under all four policies",
			sent_items, checked_rsp);
		$display("directed extremes plus random push/pop/advance mixes with stalls");
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule

// ===== ready_queue_policy_scheduler_unit.f =====
+incdir+rtl/core
rtl/core/rqs_pkg.sv
rtl/core/rqs_req_if.sv
rtl/core/rqs_rsp_if.sv
rtl/core/ready_queue_policy_scheduler_unit.sv
verif/tb_ready_queue_policy_scheduler_unit.sv
